[design/pcb_pkg.sv]
// ----------------------------------------------------------------------------
// pcb_pkg: shared types and constants for particle cell binning
// Field widths, status codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package pcb_pkg;

   // default sizing
   localparam int MAX_CELLS_PER_DIM_DEF = 8;
   localparam int CELL_CAPACITY_DEF     = 64;

   // fixed field widths
   localparam int POS_W      = 32;
   localparam int CELLS_W    = 4;
   localparam int STATUS_W   = 2;
   localparam int INDEX_W    = 9;
   localparam int SLOT_W     = 6;
   localparam int TOTAL_W    = 32;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_STORED       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OUT_OF_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_CELL_FULL    = 2'd2;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_CELLS_X = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_CELLS_Y = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_CELLS_Z = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_CUTOFF  = 2'd3;

   // register reset values
   localparam logic [CELLS_W-1:0] CELLS_RESET  = 4'd8;
   localparam logic [POS_W-1:0]   CUTOFF_RESET = 32'd557056;

endpackage

[design/pcb_divider.sv]
// ----------------------------------------------------------------------------
// pcb_divider: shared restoring divider for cell coordinates
// One quotient bit per cycle, QW+1 bits. A quotient that would not fit
// comes out with its top bit set, which is always out of the grid.
// ----------------------------------------------------------------------------
module pcb_divider
   import pcb_pkg::*;
#(
   parameter int MAX_CELLS_PER_DIM = MAX_CELLS_PER_DIM_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [POS_W-1:0]                  dividend,
   input  logic [POS_W-1:0]                  divisor,
   output logic                              done,
   output logic [$clog2(MAX_CELLS_PER_DIM):0] quot
);

   localparam int QW = $clog2(MAX_CELLS_PER_DIM);
   localparam int QN = QW + 1;
   localparam int DW = POS_W + QW;
   localparam int SW = (QW > 0) ? $clog2(QW + 1) : 1;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [SW-1:0]    step_ff, step_in;
   logic [POS_W-1:0] rem_ff, rem_in;
   logic [POS_W-1:0] divisor_ff, divisor_in;
   logic [QN-1:0]    quot_ff, quot_in;
   logic [DW-1:0]    rem_ext, shifted, diff;
   logic             fits;

   // trial subtract of the shifted divisor
   always_comb begin
      rem_ext = DW'(rem_ff);
      shifted = DW'(divisor_ff) << step_ff;
      fits    = rem_ext >= shifted;
      diff    = rem_ext - shifted;
   end

   // step sequencing
   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      rem_in     = rem_ff;
      quot_in    = quot_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         step_in    = SW'(QW);
         rem_in     = dividend;
         quot_in    = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in  = diff[POS_W-1:0];
            quot_in = quot_ff | (QN'(1) << step_ff);
         end
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - SW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff    <= step_in;
      rem_ff     <= rem_in;
      quot_ff    <= quot_in;
      divisor_ff <= divisor_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

[design/particle_cell_binning.sv]
// ----------------------------------------------------------------------------
// particle_cell_binning: cell-list binning of particle positions
// Divides each coordinate by the cell edge, bins in-range particles into a
// per-cell slot store and keeps running stored and out-of-range totals.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake          Payload
//  req_      in         req_valid/stall    pos_x, pos_y, pos_z, last_particle
//  rsp_      out        rsp_valid/stall    status, bin_index, slot, totals,
//                                          frame_done
//  csr_      in         csr_write_en       csr_index, csr_wdata
//
// Each request runs through the single shared divider, which works the z, y
// and x axes in turn, then fetches its cell's fill count and updates the
// result register; the divider is skipped when the cutoff is zero and the
// later axes once one falls off the grid. Requests are taken one at a time.
// After reset a clearing pass writes all MAX_CELLS_PER_DIM**3 fill counts
// (512 by default) to zero, with req_stall high.
// A stalled result waits in the output register; the next request is taken
// meanwhile and only its final update waits for the register to free up.
// ----------------------------------------------------------------------------
module particle_cell_binning
   import pcb_pkg::*;
#(
   parameter int MAX_CELLS_PER_DIM = MAX_CELLS_PER_DIM_DEF,
   parameter int CELL_CAPACITY     = CELL_CAPACITY_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [POS_W-1:0]      req_pos_x,
   input  logic [POS_W-1:0]      req_pos_y,
   input  logic [POS_W-1:0]      req_pos_z,
   input  logic                  req_last_particle,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [INDEX_W-1:0]    rsp_bin_index,
   output logic [SLOT_W-1:0]     rsp_slot,
   output logic [TOTAL_W-1:0]    rsp_stored_total,
   output logic [TOTAL_W-1:0]    rsp_out_of_range_total,
   output logic                  rsp_frame_done,
   // register write port
   input  logic                  csr_write_en,
   input  logic [CSR_ADDR_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int QN          = $clog2(MAX_CELLS_PER_DIM) + 1;
   localparam int NW          = $clog2(MAX_CELLS_PER_DIM + 1);
   localparam int CELL_DEPTH  = MAX_CELLS_PER_DIM ** 3;
   localparam int CIW         = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1;
   localparam int PW          = CIW + NW;
   localparam int FW          = $clog2(CELL_CAPACITY + 1);
   localparam int STORE_DEPTH = CELL_DEPTH * CELL_CAPACITY;
   localparam int SAW         = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   // sequencer states
   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_DIV    = 3'd2;
   localparam logic [2:0] ST_FETCH  = 3'd3;
   localparam logic [2:0] ST_UPDATE = 3'd4;

   // axis order through the divider
   localparam logic [1:0] AXIS_Z = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_X = 2'd2;

   logic [2:0]          state_ff, state_in;
   logic [CIW-1:0]      clr_ff, clr_in;
   logic [1:0]          axis_ff, axis_in;
   logic [CIW-1:0]      acc_ff, acc_in;
   logic                oor_ff, oor_in;
   logic [POS_W-1:0]    pos_x_ff, pos_x_in;
   logic [POS_W-1:0]    pos_y_ff, pos_y_in;
   logic [POS_W-1:0]    pos_z_ff, pos_z_in;
   logic                last_ff, last_in;
   logic [FW-1:0]       fill_rd_ff;
   logic [TOTAL_W-1:0]  stored_cnt_ff, stored_cnt_in;
   logic [TOTAL_W-1:0]  rej_cnt_ff, rej_cnt_in;
   logic [CELLS_W-1:0]  cells_x_ff, cells_x_in;
   logic [CELLS_W-1:0]  cells_y_ff, cells_y_in;
   logic [CELLS_W-1:0]  cells_z_ff, cells_z_in;
   logic [POS_W-1:0]    cutoff_ff, cutoff_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [INDEX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [TOTAL_W-1:0]  rsp_stored_ff, rsp_stored_in;
   logic [TOTAL_W-1:0]  rsp_rej_ff, rsp_rej_in;
   logic                rsp_done_ff, rsp_done_in;

   logic [FW-1:0]       fill_mem [CELL_DEPTH];
   logic [3*POS_W-1:0]  pos_mem [STORE_DEPTH];

   logic                fill_we;
   logic [CIW-1:0]      fill_waddr;
   logic [FW-1:0]       fill_wdata;
   logic                store_we;
   logic [SAW-1:0]      store_addr;

   logic                div_start;
   logic [POS_W-1:0]    div_dividend;
   logic                div_done;
   logic [QN-1:0]       div_quot;

   logic [NW-1:0]       n_x, n_y, n_z, n_cur;
   logic                q_in_range;
   logic [PW-1:0]       acc_sum;
   logic                out_free;
   logic [TOTAL_W-1:0]  stored_sat, rej_sat;

   // shared divider
   pcb_divider #(
      .MAX_CELLS_PER_DIM (MAX_CELLS_PER_DIM)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (cutoff_ff),
      .done     (div_done),
      .quot     (div_quot)
   );

   // grid size clamped to the build limit
   always_comb begin
      n_x = (32'(cells_x_ff) > 32'(MAX_CELLS_PER_DIM)) ? NW'(MAX_CELLS_PER_DIM)
                                                        : NW'(cells_x_ff);
      n_y = (32'(cells_y_ff) > 32'(MAX_CELLS_PER_DIM)) ? NW'(MAX_CELLS_PER_DIM)
                                                        : NW'(cells_y_ff);
      n_z = (32'(cells_z_ff) > 32'(MAX_CELLS_PER_DIM)) ? NW'(MAX_CELLS_PER_DIM)
                                                        : NW'(cells_z_ff);
      case (axis_ff)
         AXIS_Z:  n_cur = n_z;
         AXIS_Y:  n_cur = n_y;
         default: n_cur = n_x;
      endcase
   end

   // range check and Horner step of the linear index: (z*ny + y)*nx + x
   always_comb begin
      q_in_range = 32'(div_quot) < 32'(n_cur);
      if (axis_ff == AXIS_Z) begin
         acc_sum = PW'(div_quot);
      end else begin
         acc_sum = PW'(acc_ff) * PW'(n_cur) + PW'(div_quot);
      end
   end

   // saturating totals
   always_comb begin
      stored_sat = (stored_cnt_ff == '1) ? stored_cnt_ff : stored_cnt_ff + TOTAL_W'(1);
      rej_sat    = (rej_cnt_ff == '1) ? rej_cnt_ff : rej_cnt_ff + TOTAL_W'(1);
   end

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign store_addr = SAW'(acc_ff) * SAW'(CELL_CAPACITY) + SAW'(fill_rd_ff);

   // register writes
   always_comb begin
      cells_x_in = cells_x_ff;
      cells_y_in = cells_y_ff;
      cells_z_in = cells_z_ff;
      cutoff_in  = cutoff_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_CELLS_X: cells_x_in = csr_wdata[CELLS_W-1:0];
            CSR_CELLS_Y: cells_y_in = csr_wdata[CELLS_W-1:0];
            CSR_CELLS_Z: cells_z_in = csr_wdata[CELLS_W-1:0];
            CSR_CUTOFF:  cutoff_in  = csr_wdata[POS_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      axis_in       = axis_ff;
      acc_in        = acc_ff;
      oor_in        = oor_ff;
      pos_x_in      = pos_x_ff;
      pos_y_in      = pos_y_ff;
      pos_z_in      = pos_z_ff;
      last_in       = last_ff;
      stored_cnt_in = stored_cnt_ff;
      rej_cnt_in    = rej_cnt_ff;
      div_start     = 1'b0;
      div_dividend  = req_pos_z;
      fill_we       = 1'b0;
      fill_waddr    = acc_ff;
      fill_wdata    = fill_rd_ff + FW'(1);
      store_we      = 1'b0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_stored_in = rsp_stored_ff;
      rsp_rej_in    = rsp_rej_ff;
      rsp_done_in   = rsp_done_ff;

      case (state_ff)
         ST_CLEAR: begin
            fill_we    = 1'b1;
            fill_waddr = clr_ff;
            fill_wdata = '0;
            if (clr_ff == CIW'(CELL_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + CIW'(1);
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               pos_x_in = req_pos_x;
               pos_y_in = req_pos_y;
               pos_z_in = req_pos_z;
               last_in  = req_last_particle;
               axis_in  = AXIS_Z;
               acc_in   = '0;
               if (cutoff_ff == '0) begin
                  oor_in   = 1'b1;
                  state_in = ST_UPDATE;
               end else begin
                  oor_in    = 1'b0;
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               if (!q_in_range) begin
                  oor_in   = 1'b1;
                  state_in = ST_UPDATE;
               end else begin
                  acc_in = acc_sum[CIW-1:0];
                  case (axis_ff)
                     AXIS_Z: begin
                        axis_in      = AXIS_Y;
                        div_start    = 1'b1;
                        div_dividend = pos_y_ff;
                     end
                     AXIS_Y: begin
                        axis_in      = AXIS_X;
                        div_start    = 1'b1;
                        div_dividend = pos_x_ff;
                     end
                     default: state_in = ST_FETCH;
                  endcase
               end
            end
         end
         ST_FETCH: begin
            // fill count read of the final index lands this cycle
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_done_in  = last_ff;
               state_in     = ST_IDLE;
               if (oor_ff) begin
                  rej_cnt_in    = rej_sat;
                  rsp_status_in = STATUS_OUT_OF_RANGE;
                  rsp_index_in  = '0;
                  rsp_slot_in   = '0;
                  rsp_stored_in = stored_cnt_ff;
                  rsp_rej_in    = rej_sat;
               end else if (32'(fill_rd_ff) >= 32'(CELL_CAPACITY)) begin
                  rsp_status_in = STATUS_CELL_FULL;
                  rsp_index_in  = INDEX_W'(acc_ff);
                  rsp_slot_in   = '0;
                  rsp_stored_in = stored_cnt_ff;
                  rsp_rej_in    = rej_cnt_ff;
               end else begin
                  fill_we       = 1'b1;
                  store_we      = 1'b1;
                  stored_cnt_in = stored_sat;
                  rsp_status_in = STATUS_STORED;
                  rsp_index_in  = INDEX_W'(acc_ff);
                  rsp_slot_in   = SLOT_W'(fill_rd_ff);
                  rsp_stored_in = stored_sat;
                  rsp_rej_in    = rej_cnt_ff;
               end
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         stored_cnt_ff <= '0;
         rej_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         cells_x_ff    <= CELLS_RESET;
         cells_y_ff    <= CELLS_RESET;
         cells_z_ff    <= CELLS_RESET;
         cutoff_ff     <= CUTOFF_RESET;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         stored_cnt_ff <= stored_cnt_in;
         rej_cnt_ff    <= rej_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
         cells_x_ff    <= cells_x_in;
         cells_y_ff    <= cells_y_in;
         cells_z_ff    <= cells_z_in;
         cutoff_ff     <= cutoff_in;
      end
   end

   // request payload and result register
   always_ff @(posedge clock) begin
      axis_ff       <= axis_in;
      acc_ff        <= acc_in;
      oor_ff        <= oor_in;
      pos_x_ff      <= pos_x_in;
      pos_y_ff      <= pos_y_in;
      pos_z_ff      <= pos_z_in;
      last_ff       <= last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_stored_ff <= rsp_stored_in;
      rsp_rej_ff    <= rsp_rej_in;
      rsp_done_ff   <= rsp_done_in;
   end

   // per-cell fill counts, registered read
   always_ff @(posedge clock) begin
      if (fill_we) begin
         fill_mem[fill_waddr] <= fill_wdata;
      end
      fill_rd_ff <= fill_mem[acc_ff];
   end

   // per-cell slot store of positions
   always_ff @(posedge clock) begin
      if (store_we) begin
         pos_mem[store_addr] <= {pos_z_ff, pos_y_ff, pos_x_ff};
      end
   end

   assign req_stall              = (state_ff != ST_IDLE);
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status             = rsp_status_ff;
   assign rsp_bin_index          = rsp_index_ff;
   assign rsp_slot               = rsp_slot_ff;
   assign rsp_stored_total       = rsp_stored_ff;
   assign rsp_out_of_range_total = rsp_rej_ff;
   assign rsp_frame_done         = rsp_done_ff;

endmodule

[design/pcb_checker.sv]
// ----------------------------------------------------------------------------
// pcb_checker: port-level checks for particle cell binning
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module pcb_checker
   import pcb_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [INDEX_W-1:0]  rsp_bin_index,
   input logic [SLOT_W-1:0]   rsp_slot,
   input logic [TOTAL_W-1:0]  rsp_stored_total,
   input logic [TOTAL_W-1:0]  rsp_out_of_range_total
);

   // no response is left over from before reset
   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // one request at a time: the block is busy after taking one
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while a request is in work");

   // rejected particles name no cell and no slot
   a_oor_no_cell: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_OUT_OF_RANGE |->
         rsp_bin_index == '0 && rsp_slot == '0)
      else $error("out-of-range response carries a cell or slot");

   // a stalled response holds its totals
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_stored_total) &&
         $stable(rsp_out_of_range_total))
      else $error("stalled response dropped or changed");

endmodule

bind particle_cell_binning pcb_checker u_pcb_checker (.*);
